@@ sv/s256h_pkg.sv @@
`default_nettype none

package s256h_pkg;

  localparam int unsigned DigestWords = 8;
  localparam int unsigned WindowWords = 16;
  localparam int unsigned Rounds = 64;

  localparam logic [5:0] FillLast = 6'd63;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [5:0] RoundLast = 6'd63;
  localparam logic [2:0] WordLast = 3'd7;
  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [63:0] BitsPerByte = 64'd8;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_e;

  localparam word_t InitChain [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    unique case (r)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    round_k = k;
  endfunction

endpackage

`default_nettype wire

@@ sv/s256h_in_if.sv @@
`default_nettype none

interface s256h_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte, output end_of_message,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input end_of_message,
                output ready);
endinterface

`default_nettype wire

@@ sv/s256h_out_if.sv @@
`default_nettype none

interface s256h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

`default_nettype wire

@@ sv/sha256_stream_hasher.sv @@
// a request without end of message is taken while idle; each 64th byte starts a compression
// (64 rounds through the one round unit, then a fold into the chain)
// end of message: one pad byte per cycle up to the block end and a compression,
// twice when the length needs an extra block; then 8 digest words, one per accepted cycle
// reset loads the initial hash values and clears counters, flags and the sequencer;
// the schedule window and working variables are not reset
`default_nettype none

module sha256_stream_hasher import s256h_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  s256h_in_if.sink     in_if,
  s256h_out_if.source  out_if
);

  state_e state_q, state_d;
  state_e after_q, after_d;

  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [5:0]  round_q;
  logic [2:0]  idx_q;
  logic        mark_q;
  logic        len_q;

  word_t chain_q [DigestWords];
  word_t wv_q [DigestWords];
  word_t win_q [WindowWords];

  logic       in_acc;
  logic       out_acc;
  logic       len_now;
  logic       shift_en;
  logic [7:0] shift_byte;
  logic       mark_set;
  logic       len_set;
  logic       load_wv;
  logic       emit_done;
  logic [7:0] len_byte;

  word_t t1;
  word_t t2;
  word_t w_new;

  assign in_acc  = in_if.valid && in_if.ready;
  assign out_acc = out_if.valid && out_if.ready;
  assign len_now = mark_q && (len_q || (fill_q == LenStart));
  assign len_byte = 8'(bits_q >> {~fill_q[2:0], 3'b000});

  // next state
  always_comb begin
    state_d = state_q;
    after_d = after_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_if.has_byte && (fill_q == FillLast)) begin
            state_d = ST_ROUND;
            after_d = in_if.end_of_message ? ST_PAD : ST_IDLE;
          end else if (in_if.end_of_message) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_q == FillLast) begin
          state_d = ST_ROUND;
          after_d = len_now ? ST_EMIT : ST_PAD;
        end
      end
      ST_ROUND: begin
        if (round_q == RoundLast) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        state_d = after_q;
      end
      ST_EMIT: begin
        if (out_acc && (idx_q == WordLast)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    shift_en   = 1'b0;
    shift_byte = '0;
    mark_set   = 1'b0;
    len_set    = 1'b0;
    emit_done  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        shift_en   = in_acc && in_if.has_byte;
        shift_byte = in_if.data_byte;
      end
      ST_PAD: begin
        shift_en = 1'b1;
        if (!mark_q) begin
          shift_byte = PadMarker;
          mark_set   = 1'b1;
        end else if (len_now) begin
          shift_byte = len_byte;
          len_set    = 1'b1;
        end
      end
      ST_EMIT: begin
        emit_done = out_acc && (idx_q == WordLast);
      end
      default: begin
        shift_en = 1'b0;
      end
    endcase
  end

  assign load_wv = (state_d == ST_ROUND) && (state_q != ST_ROUND);

  assign in_if.ready        = (state_q == ST_IDLE);
  assign out_if.valid       = (state_q == ST_EMIT);
  assign out_if.digest_word = chain_q[idx_q];
  assign out_if.word_index  = idx_q;
  assign out_if.last_word   = (idx_q == WordLast);

  // shared round unit
  always_comb begin
    t1 = wv_q[7] + big_sigma1(wv_q[4]) + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
         + round_k(round_q) + win_q[0];
    t2 = big_sigma0(wv_q[0])
         + ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
    w_new = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      after_q <= ST_IDLE;
      fill_q  <= '0;
      bits_q  <= '0;
      round_q <= '0;
      idx_q   <= '0;
      mark_q  <= 1'b0;
      len_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      if (shift_en) begin
        fill_q <= fill_q + 6'd1;
      end
      if (emit_done) begin
        bits_q <= '0;
      end else if (in_acc && in_if.has_byte) begin
        bits_q <= bits_q + BitsPerByte;
      end
      if (state_q == ST_ROUND) begin
        round_q <= round_q + 6'd1;
      end
      if (out_acc) begin
        idx_q <= idx_q + 3'd1;
      end
      if (emit_done) begin
        mark_q <= 1'b0;
        len_q  <= 1'b0;
      end else begin
        if (mark_set) begin
          mark_q <= 1'b1;
        end
        if (len_set) begin
          len_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= InitChain;
    end else if (emit_done) begin
      chain_q <= InitChain;
    end else if (state_q == ST_FOLD) begin
      for (int i = 0; i < DigestWords; i++) begin
        chain_q[i] <= chain_q[i] + wv_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wv) begin
      wv_q <= chain_q;
    end else if (state_q == ST_ROUND) begin
      wv_q[7] <= wv_q[6];
      wv_q[6] <= wv_q[5];
      wv_q[5] <= wv_q[4];
      wv_q[4] <= wv_q[3] + t1;
      wv_q[3] <= wv_q[2];
      wv_q[2] <= wv_q[1];
      wv_q[1] <= wv_q[0];
      wv_q[0] <= t1 + t2;
    end
  end

  // message bytes shift in big-endian; during rounds the window shifts by words
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < WindowWords - 1; i++) begin
        win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_q[WindowWords-1] <= {win_q[WindowWords-1][23:0], shift_byte};
    end else if (state_q == ST_ROUND) begin
      for (int i = 0; i < WindowWords - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WindowWords-1] <= w_new;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid))
    else $error("input and output sides active together");

  a_round_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ROUND) |-> (round_q == '0))
    else $error("round counter not cleared outside compression");

  a_len_after_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q |-> mark_q)
    else $error("length bytes without pad marker");

  a_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_done |=> (state_q == ST_IDLE) && (fill_q == '0) && (bits_q == '0) && !mark_q)
    else $error("message state not reinitialised after digest");

endmodule

`default_nettype wire
